/* rtl/hrd_pkg.sv */
package hrd_pkg;

  localparam int unsigned MaxHeaderRows  = 50;
  localparam int unsigned MaxLineLen     = 256;
  localparam int unsigned SizeFieldChars = 5;

  localparam int unsigned StatusLen = 3;
  localparam int unsigned ChunkLen  = 26;
  localparam int unsigned LengthLen = 15;

  localparam logic [23:0] Max24 = 24'hFFFFFF;

  // event kinds
  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindLast  = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;
  localparam logic [1:0] KindError = 2'd3;

  // error codes
  localparam logic [2:0] ErrNo200    = 3'd0;
  localparam logic [2:0] ErrNoLength = 3'd1;
  localparam logic [2:0] ErrRows     = 3'd2;
  localparam logic [2:0] ErrLine     = 3'd3;
  localparam logic [2:0] ErrSize     = 3'd4;
  localparam logic [2:0] ErrChunk    = 3'd5;

  // framing modes
  localparam logic [1:0] FrameNone    = 2'd0;
  localparam logic [1:0] FrameChunked = 2'd1;
  localparam logic [1:0] FrameLength  = 2'd2;

  // chunk phases
  localparam logic [2:0] ChSize  = 3'd0;
  localparam logic [2:0] ChTail  = 3'd1;
  localparam logic [2:0] ChData  = 3'd2;
  localparam logic [2:0] ChDCr   = 3'd3;
  localparam logic [2:0] ChDLf   = 3'd4;
  localparam logic [2:0] ChFCr   = 3'd5;
  localparam logic [2:0] ChFLf   = 3'd6;

  // length value phases
  localparam logic [1:0] LpBlank = 2'd0;
  localparam logic [1:0] LpDigit = 2'd1;
  localparam logic [1:0] LpDone  = 2'd2;

  function automatic logic [7:0] status_char(input logic [1:0] i);
    logic [7:0] r;
    r = (i == 2'd0) ? 8'h32 : 8'h30;
    return r;
  endfunction

  function automatic logic [7:0] chunk_char(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = "T";  5'd1: r = "r";  5'd2: r = "a";  5'd3: r = "n";
      5'd4: r = "s";  5'd5: r = "f";  5'd6: r = "e";  5'd7: r = "r";
      5'd8: r = "-";  5'd9: r = "E";  5'd10: r = "n"; 5'd11: r = "c";
      5'd12: r = "o"; 5'd13: r = "d"; 5'd14: r = "i"; 5'd15: r = "n";
      5'd16: r = "g"; 5'd17: r = ":"; 5'd18: r = " "; 5'd19: r = "c";
      5'd20: r = "h"; 5'd21: r = "u"; 5'd22: r = "n"; 5'd23: r = "k";
      5'd24: r = "e"; 5'd25: r = "d";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] length_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = "C";  4'd1: r = "o";  4'd2: r = "n";  4'd3: r = "t";
      4'd4: r = "e";  4'd5: r = "n";  4'd6: r = "t";  4'd7: r = "-";
      4'd8: r = "L";  4'd9: r = "e";  4'd10: r = "n"; 4'd11: r = "g";
      4'd12: r = "t"; 4'd13: r = "h"; 4'd14: r = ":";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // next match state; patterns have no self-overlap except a fallback to
  // the first character (and "00" in the status pattern)
  function automatic logic [1:0] status_next(input logic [1:0] k, input logic [7:0] c);
    logic [1:0] r;
    if (c == status_char(k)) r = k + 2'd1;
    else if (k == 2'd2 && c == 8'h30) r = 2'd2;
    else if (c == 8'h32) r = 2'd1;
    else r = 2'd0;
    return r;
  endfunction

  function automatic logic [4:0] chunk_next(input logic [4:0] k, input logic [7:0] c);
    logic [4:0] r;
    if (c == chunk_char(k)) r = k + 5'd1;
    else if (c == "T") r = 5'd1;
    else r = 5'd0;
    return r;
  endfunction

  function automatic logic [3:0] length_next(input logic [3:0] k, input logic [7:0] c);
    logic [3:0] r;
    if (c == length_char(k)) r = k + 4'd1;
    else if (c == "C") r = 4'd1;
    else r = 4'd0;
    return r;
  endfunction

endpackage

/* rtl/http_response_deframer_core.sv */
// HTTP response deframer: one received byte per input beat on the s_axis
// group, zero or one event per beat on the m_axis group (body byte, last
// body byte, message end, or sticky error with its code).
// Each beat is decoded by one pass of matchers, counters and the chunk/
// length framing logic between the input byte and a single result register;
// a result is valid in the cycle after its beat is accepted.
// Throughput is one byte per cycle: s_axis_tready stays high while the
// result register is empty or being emptied in the same cycle, so a
// waiting result does not block the next byte unless the receiver stalls.
// When m_axis_tready is low with a result held, tready drops and both
// sides hold. Bytes that produce no event are taken without any output.
// Reset clears all parse state: the block expects the start of a response
// header. After an error every later byte is taken and dropped until reset.
module http_response_deframer_core #(
  parameter int unsigned MAX_HEADER_ROWS  = hrd_pkg::MaxHeaderRows,
  parameter int unsigned MAX_LINE_LEN     = hrd_pkg::MaxLineLen,
  parameter int unsigned SIZE_FIELD_CHARS = hrd_pkg::SizeFieldChars
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // body_byte [7:0], error_code [10:8], zero pad
  output logic [1:0]  m_axis_tuser_o    // event_kind
);

  logic in_body_q, halted_q, prev_cr_q, status_ok_q;
  logic [5:0] rows_q;
  logic [8:0] len_q;
  logic [1:0] smatch_q, frame_q, lphase_q;
  logic [4:0] cmatch_q;
  logic [3:0] lmatch_q;
  logic [23:0] digits_q, remain_q;
  logic [2:0] cphase_q;

  logic in_body_d, halted_d, prev_cr_d, status_ok_d;
  logic [5:0] rows_d;
  logic [8:0] len_d;
  logic [1:0] smatch_d, frame_d, lphase_d;
  logic [4:0] cmatch_d;
  logic [3:0] lmatch_d;
  logic [23:0] digits_d, remain_d;
  logic [2:0] cphase_d;

  logic ovalid_q;
  logic [1:0] okind_q, okind;
  logic [7:0] obyte_q, obyte;
  logic [2:0] ocode_q, ocode;
  logic emit;

  logic accept;
  assign s_axis_tready_o = !ovalid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  logic [7:0] c;
  assign c = s_axis_tdata_i;

  logic is_dig, is_blank, is_hex;
  logic [3:0] hexv;
  always_comb begin
    is_dig = (c >= "0") && (c <= "9");
    is_blank = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    hexv = 4'd0;
    is_hex = 1'b1;
    if (is_dig) hexv = 4'(c - "0");
    else if (c >= "a" && c <= "f") hexv = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") hexv = 4'(c - "A" + 8'd10);
    else is_hex = 1'b0;
  end

  // decimal step x*10 + d with saturation
  logic [27:0] dec_wide;
  logic [23:0] dec_sat;
  always_comb begin
    dec_wide = {4'd0, digits_q} * 28'd10 + {24'd0, 4'(c - "0")};
    dec_sat = (dec_wide > {4'd0, hrd_pkg::Max24}) ? hrd_pkg::Max24 : dec_wide[23:0];
  end

  // decode of one byte
  always_comb begin
    in_body_d = in_body_q; halted_d = halted_q; prev_cr_d = prev_cr_q;
    status_ok_d = status_ok_q; rows_d = rows_q; len_d = len_q;
    smatch_d = smatch_q; frame_d = frame_q; lphase_d = lphase_q;
    cmatch_d = cmatch_q; lmatch_d = lmatch_q; digits_d = digits_q;
    remain_d = remain_q; cphase_d = cphase_q;
    emit = 1'b0; okind = hrd_pkg::KindByte; obyte = 8'd0; ocode = 3'd0;

    if (halted_q) begin
      emit = 1'b0;
    end else if (!in_body_q) begin
      if (rows_q == 6'd0 && !status_ok_q) begin
        smatch_d = hrd_pkg::status_next(smatch_q, c);
        if (smatch_d == 2'(hrd_pkg::StatusLen)) begin
          status_ok_d = 1'b1; smatch_d = 2'd0;
        end
      end
      if (cmatch_q < 5'(hrd_pkg::ChunkLen)) cmatch_d = hrd_pkg::chunk_next(cmatch_q, c);
      if (lmatch_q >= 4'(hrd_pkg::LengthLen)) begin
        if (frame_q == hrd_pkg::FrameNone) begin
          case (lphase_q)
            hrd_pkg::LpBlank: begin
              if (is_blank) lphase_d = hrd_pkg::LpBlank;
              else if (c == "+") lphase_d = hrd_pkg::LpDigit;
              else if (!is_dig) lphase_d = hrd_pkg::LpDone;
              else begin lphase_d = hrd_pkg::LpDigit; digits_d = dec_sat; end
            end
            hrd_pkg::LpDigit: begin
              if (is_dig) digits_d = dec_sat;
              else lphase_d = hrd_pkg::LpDone;
            end
            default: lphase_d = hrd_pkg::LpDone;
          endcase
        end
      end else begin
        lmatch_d = hrd_pkg::length_next(lmatch_q, c);
      end

      if (prev_cr_q && c == 8'h0A) begin
        if (len_q == 9'd1) begin
          if (!status_ok_q) begin
            halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
            ocode = hrd_pkg::ErrNo200;
          end else if (frame_q == hrd_pkg::FrameNone) begin
            halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
            ocode = hrd_pkg::ErrNoLength;
          end else if (frame_q == hrd_pkg::FrameChunked) begin
            in_body_d = 1'b1; cphase_d = hrd_pkg::ChSize; remain_d = 24'd0;
            len_d = 9'd0; prev_cr_d = 1'b0;
          end else if (digits_q == 24'd0) begin
            emit = 1'b1; okind = hrd_pkg::KindEnd;
            in_body_d = 1'b0; rows_d = 6'd0; status_ok_d = 1'b0;
            frame_d = hrd_pkg::FrameNone; remain_d = 24'd0; cphase_d = hrd_pkg::ChSize;
            len_d = 9'd0; prev_cr_d = 1'b0; smatch_d = 2'd0; cmatch_d = 5'd0;
            lmatch_d = 4'd0; lphase_d = hrd_pkg::LpBlank; digits_d = 24'd0;
          end else begin
            in_body_d = 1'b1; remain_d = digits_q;
          end
        end else begin
          if (frame_q == hrd_pkg::FrameNone) begin
            if (cmatch_d == 5'(hrd_pkg::ChunkLen)) frame_d = hrd_pkg::FrameChunked;
            else if (lmatch_d == 4'(hrd_pkg::LengthLen)) frame_d = hrd_pkg::FrameLength;
          end
          if (7'(rows_q) + 7'd1 >= 7'(MAX_HEADER_ROWS)) begin
            halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
            ocode = hrd_pkg::ErrRows;
          end else begin
            rows_d = rows_q + 6'd1;
            len_d = 9'd0; prev_cr_d = 1'b0; smatch_d = 2'd0; cmatch_d = 5'd0;
            lmatch_d = 4'd0; lphase_d = hrd_pkg::LpBlank;
            if (frame_d == hrd_pkg::FrameNone) digits_d = 24'd0;
          end
        end
      end else if (len_q >= 9'(MAX_LINE_LEN)) begin
        halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
        ocode = hrd_pkg::ErrLine;
      end else begin
        len_d = len_q + 9'd1;
        prev_cr_d = (c == 8'h0D);
      end
    end else if (frame_q == hrd_pkg::FrameChunked) begin
      case (cphase_q)
        hrd_pkg::ChSize, hrd_pkg::ChTail: begin
          if (len_q >= 9'(SIZE_FIELD_CHARS + 1)) begin
            halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
            ocode = hrd_pkg::ErrSize;
          end else if (prev_cr_q && c == 8'h0A) begin
            cphase_d = (remain_q == 24'd0) ? hrd_pkg::ChFCr : hrd_pkg::ChData;
            len_d = 9'd0; prev_cr_d = 1'b0;
          end else begin
            len_d = len_q + 9'd1;
            prev_cr_d = (c == 8'h0D);
            if (cphase_q == hrd_pkg::ChSize) begin
              if (is_hex) begin
                remain_d = (remain_q > 24'h0FFFFF) ? hrd_pkg::Max24
                                                  : {remain_q[19:0], hexv};
              end else if (len_q == 9'd0) begin
                halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
                ocode = hrd_pkg::ErrSize;
              end else begin
                cphase_d = hrd_pkg::ChTail;
              end
            end
          end
        end
        hrd_pkg::ChData: begin
          emit = 1'b1; okind = hrd_pkg::KindByte; obyte = c;
          if (remain_q <= 24'd1) begin
            remain_d = 24'd0; cphase_d = hrd_pkg::ChDCr;
          end else begin
            remain_d = remain_q - 24'd1;
          end
        end
        hrd_pkg::ChDCr, hrd_pkg::ChFCr: begin
          if (c != 8'h0D) begin
            halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
            ocode = hrd_pkg::ErrChunk;
          end else begin
            cphase_d = cphase_q + 3'd1;
          end
        end
        hrd_pkg::ChDLf: begin
          if (c != 8'h0A) begin
            halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
            ocode = hrd_pkg::ErrChunk;
          end else begin
            cphase_d = hrd_pkg::ChSize; len_d = 9'd0; prev_cr_d = 1'b0;
          end
        end
        hrd_pkg::ChFLf: begin
          if (c != 8'h0A) begin
            halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
            ocode = hrd_pkg::ErrChunk;
          end else begin
            emit = 1'b1; okind = hrd_pkg::KindEnd;
            in_body_d = 1'b0; rows_d = 6'd0; status_ok_d = 1'b0;
            frame_d = hrd_pkg::FrameNone; remain_d = 24'd0; cphase_d = hrd_pkg::ChSize;
            len_d = 9'd0; prev_cr_d = 1'b0; smatch_d = 2'd0; cmatch_d = 5'd0;
            lmatch_d = 4'd0; lphase_d = hrd_pkg::LpBlank; digits_d = 24'd0;
          end
        end
        default: begin
          halted_d = 1'b1; emit = 1'b1; okind = hrd_pkg::KindError;
          ocode = hrd_pkg::ErrChunk;
        end
      endcase
    end else begin
      emit = 1'b1; obyte = c;
      if (remain_q <= 24'd1) begin
        okind = hrd_pkg::KindLast;
        in_body_d = 1'b0; rows_d = 6'd0; status_ok_d = 1'b0;
        frame_d = hrd_pkg::FrameNone; remain_d = 24'd0; cphase_d = hrd_pkg::ChSize;
        len_d = 9'd0; prev_cr_d = 1'b0; smatch_d = 2'd0; cmatch_d = 5'd0;
        lmatch_d = 4'd0; lphase_d = hrd_pkg::LpBlank; digits_d = 24'd0;
      end else begin
        okind = hrd_pkg::KindByte;
        remain_d = remain_q - 24'd1;
      end
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0; halted_q <= 1'b0; prev_cr_q <= 1'b0; status_ok_q <= 1'b0;
      rows_q <= '0; len_q <= '0; smatch_q <= '0; frame_q <= hrd_pkg::FrameNone;
      lphase_q <= hrd_pkg::LpBlank; cmatch_q <= '0; lmatch_q <= '0;
      digits_q <= '0; remain_q <= '0; cphase_q <= hrd_pkg::ChSize;
    end else if (accept) begin
      in_body_q <= in_body_d; halted_q <= halted_d; prev_cr_q <= prev_cr_d;
      status_ok_q <= status_ok_d; rows_q <= rows_d; len_q <= len_d;
      smatch_q <= smatch_d; frame_q <= frame_d; lphase_q <= lphase_d;
      cmatch_q <= cmatch_d; lmatch_q <= lmatch_d; digits_q <= digits_d;
      remain_q <= remain_d; cphase_q <= cphase_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      ovalid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      okind_q <= okind; obyte_q <= obyte; ocode_q <= ocode;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tdata_o  = {5'd0, ocode_q, obyte_q};

  // held result is not overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result lost under stall");
  // once halted, no new result follows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halted_q) && halted_q && $past(accept) |-> !($rose(ovalid_q)) || !$past(accept && emit))
    else $error("result after halt");
  // halt is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halt cleared");
  // an error result always comes with halted state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == hrd_pkg::KindError |-> halted_q)
    else $error("error without halt");

endmodule
